[src/sbrp_pkg.sv]
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants for the servo bus reply parser: frame record,
// parser states, protocol constants and queue sizing.
// ----------------------------------------------------------------------------
package sbrp_pkg;

    // Protocol constants
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] LEN_MIN    = 8'd3;
    localparam logic [7:0] LEN_MAX    = 8'd7;
    localparam logic [2:0] PCOUNT_OFS = 3'd3;
    localparam int         NUM_PARAMS = 4;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;

    // Parser states
    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HDR,
        ST_ID,
        ST_LEN,
        ST_BODY
    } t_state;

    // One parsed reply frame
    typedef struct packed {
        logic                        status;
        logic [7:0]                  servo_id;
        logic [7:0]                  command;
        logic [2:0]                  param_count;
        logic [NUM_PARAMS-1:0][7:0]  params;
    } t_frame;

    // Queue status seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[src/servo_bus_reply_parser_top.sv]
// ----------------------------------------------------------------------------
// servo_bus_reply_parser_top
// Receiver for bus-servo reply frames: one received byte per transaction in,
// one parsed frame per transaction out.
//
// Slave stream carries received bytes; the block accepts a byte every cycle
// as long as its two-entry frame queue has room. The parser hunts for two
// header bytes, then collects id, length, command, up to four parameters and
// the checksum. Bad lengths drop the frame silently.
// Master stream carries one result per complete frame: after the checksum
// byte is taken, the frame is written into the queue and then into the
// output register. tuser flags a checksum mismatch. Unused parameter bytes
// are zero. When the receiver stalls, the output register holds its frame,
// up to two more frames wait in the queue, and tready on the byte side drops
// only while the queue is full. Throughput is one byte per cycle while the
// queue has room; the parser updates its checksum with each accepted byte.
// Reset (synchronous, active low) returns the parser to hunting and empties
// the queue and output register.
// ----------------------------------------------------------------------------
module servo_bus_reply_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream; tdata: rx_byte[7:0]
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [sbrp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Master stream; tdata: servo_id[7:0], command[15:8], param_count[18:16],
    // param0[26:19], param1[34:27], param2[42:35], param3[50:43], zero fill
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [sbrp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: status[0]
    output logic [sbrp_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    logic                w_push;
    logic                w_pop;
    sbrp_pkg::t_frame    w_wr_frame;
    sbrp_pkg::t_frame    w_rd_frame;
    sbrp_pkg::t_q_status w_q_status;

    sbrp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_byte     (i_s_axis_tdata),
        .i_q_status (w_q_status),
        .o_ready    (o_s_axis_tready),
        .o_push     (w_push),
        .o_frame    (w_wr_frame)
    );

    sbrp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_wr_frame),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_frame),
        .o_status  (w_q_status)
    );

    sbrp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (w_rd_frame),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser)
    );

endmodule

[src/sbrp_front.sv]
// ----------------------------------------------------------------------------
// sbrp_front
// Byte parser: hunts for the double header, collects id, length, command and
// parameters, checks the checksum and pushes one frame record per reply.
// ----------------------------------------------------------------------------
module sbrp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  sbrp_pkg::t_q_status  i_q_status,
    output logic                 o_ready,
    output logic                 o_push,
    output sbrp_pkg::t_frame     o_frame
);

    sbrp_pkg::t_state r_state, n_state;
    logic [2:0]       r_pos, n_pos;
    logic [2:0]       r_len, n_len;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_id, n_id;
    logic [7:0]       r_cmd, n_cmd;
    logic [sbrp_pkg::NUM_PARAMS-1:0][7:0] r_param, n_param;

    logic       w_accept;
    logic [2:0] w_count;

    // Take a byte whenever the queue has room
    assign o_ready  = ~i_q_status.full;
    assign w_accept = i_valid & o_ready;
    assign w_count  = r_len - sbrp_pkg::PCOUNT_OFS;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbrp_pkg::ST_HUNT;
            r_pos   <= '0;
            r_len   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_sum   <= n_sum;
        end
    end

    // Captured frame bytes
    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_cmd   <= n_cmd;
        r_param <= n_param;
    end

    // Next state, byte capture and frame record
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_id    = r_id;
        n_cmd   = r_cmd;
        n_param = r_param;
        o_push  = 1'b0;

        o_frame.status      = ((~r_sum) != i_byte);
        o_frame.servo_id    = r_id;
        o_frame.command     = r_cmd;
        o_frame.param_count = w_count;
        for (int k = 0; k < sbrp_pkg::NUM_PARAMS; k++) begin
            o_frame.params[k] = (3'(k) < w_count) ? r_param[k] : 8'd0;
        end

        if (w_accept) begin
            case (r_state)
                sbrp_pkg::ST_HUNT: begin
                    if (i_byte == sbrp_pkg::HDR_BYTE) begin
                        n_state = sbrp_pkg::ST_HDR;
                    end
                end
                sbrp_pkg::ST_HDR: begin
                    if (i_byte == sbrp_pkg::HDR_BYTE) begin
                        n_state = sbrp_pkg::ST_ID;
                    end else begin
                        n_state = sbrp_pkg::ST_HUNT;
                    end
                end
                sbrp_pkg::ST_ID: begin
                    // Any value is an id here, header byte included
                    n_id    = i_byte;
                    n_sum   = i_byte;
                    n_state = sbrp_pkg::ST_LEN;
                end
                sbrp_pkg::ST_LEN: begin
                    // Drop frames with an out-of-range length
                    if (i_byte < sbrp_pkg::LEN_MIN || i_byte > sbrp_pkg::LEN_MAX) begin
                        n_state = sbrp_pkg::ST_HUNT;
                    end else begin
                        n_len   = i_byte[2:0];
                        n_sum   = r_sum + i_byte;
                        n_pos   = 3'd2;
                        n_state = sbrp_pkg::ST_BODY;
                    end
                end
                sbrp_pkg::ST_BODY: begin
                    if (r_pos < r_len) begin
                        // Command at position two, parameters after it
                        if (r_pos == 3'd2) begin
                            n_cmd = i_byte;
                        end
                        for (int k = 0; k < sbrp_pkg::NUM_PARAMS; k++) begin
                            if (r_pos == 3'(k) + sbrp_pkg::PCOUNT_OFS) begin
                                n_param[k] = i_byte;
                            end
                        end
                        n_sum = r_sum + i_byte;
                        n_pos = r_pos + 3'd1;
                    end else begin
                        // Checksum byte closes the frame
                        o_push  = 1'b1;
                        n_state = sbrp_pkg::ST_HUNT;
                    end
                end
                default: begin
                    n_state = sbrp_pkg::ST_HUNT;
                end
            endcase
        end
    end

endmodule

[src/sbrp_queue.sv]
// ----------------------------------------------------------------------------
// sbrp_queue
// Short frame queue between parser and output stage, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module sbrp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sbrp_pkg::t_frame     i_wr_data,
    input  logic                 i_pop,
    output sbrp_pkg::t_frame     o_rd_data,
    output sbrp_pkg::t_q_status  o_status
);

    sbrp_pkg::t_frame                  r_mem [sbrp_pkg::QUEUE_DEPTH];
    logic [sbrp_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [sbrp_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [sbrp_pkg::QCNT_W-1:0]       r_count;

    localparam logic [sbrp_pkg::QPTR_W-1:0] PTR_LAST =
        sbrp_pkg::QPTR_W'(sbrp_pkg::QUEUE_DEPTH - 1);
    localparam logic [sbrp_pkg::QPTR_W-1:0] PTR_ONE  = sbrp_pkg::QPTR_W'(1);
    localparam logic [sbrp_pkg::QCNT_W-1:0] CNT_FULL =
        sbrp_pkg::QCNT_W'(sbrp_pkg::QUEUE_DEPTH);
    localparam logic [sbrp_pkg::QCNT_W-1:0] CNT_ONE  = sbrp_pkg::QCNT_W'(1);

    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    // Store pushed frames
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_ONE;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_ONE;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_ONE;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_ONE;
            end
        end
    end

endmodule

[src/sbrp_back.sv]
// ----------------------------------------------------------------------------
// sbrp_back
// Output stage: pulls frames from the queue into the result register and
// packs them onto the master stream.
// ----------------------------------------------------------------------------
module sbrp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sbrp_pkg::t_frame                    i_frame,
    input  sbrp_pkg::t_q_status                 i_q_status,
    output logic                                o_pop,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [sbrp_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [sbrp_pkg::OUT_TUSER_W-1:0]    o_tuser
);

    logic             r_valid;
    sbrp_pkg::t_frame r_frame;

    localparam int PACK_W = 8 + 8 + 3 + 8 * sbrp_pkg::NUM_PARAMS;

    // Refill the result register when empty or being taken
    assign o_pop = ~i_q_status.empty & (~r_valid | i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
    end

    // Pack fields from the lowest bit up
    assign o_tvalid = r_valid;
    assign o_tdata  = {{(sbrp_pkg::OUT_TDATA_W - PACK_W){1'b0}},
                       r_frame.params, r_frame.param_count,
                       r_frame.command, r_frame.servo_id};
    assign o_tuser  = r_frame.status;

endmodule

[src/sbrp_checker.sv]
// ----------------------------------------------------------------------------
// sbrp_checker
// Port-level checks for the servo bus reply parser, bound to the top level.
// ----------------------------------------------------------------------------
module sbrp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [sbrp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [sbrp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [sbrp_pkg::OUT_TUSER_W-1:0]   o_m_axis_tuser
);

    // Reset empties the output and frees the byte side
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("outputs not idle after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Parameter count never exceeds four
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[18:16] <= 3'd4)
        else $error("parameter count out of range");

    // Parameters beyond the count read as zero
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[18:16] > 3'd0 || o_m_axis_tdata[26:19] == 8'd0) &&
            (o_m_axis_tdata[18:16] > 3'd1 || o_m_axis_tdata[34:27] == 8'd0) &&
            (o_m_axis_tdata[18:16] > 3'd2 || o_m_axis_tdata[42:35] == 8'd0) &&
            (o_m_axis_tdata[18:16] > 3'd3 || o_m_axis_tdata[50:43] == 8'd0) &&
            o_m_axis_tdata[55:51] == 5'd0)
        else $error("unused parameter bytes not zero");

endmodule

bind servo_bus_reply_parser_top sbrp_checker u_sbrp_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for servo_bus_reply_parser_top. Received bytes are fed
// on the slave stream and each byte accepted also steps a local frame parser.
// Frames that parser completes are queued, and every transaction on the
// master stream is checked field by field against the oldest queued frame.
// A short table of hand-written bytes runs first, with some results typed
// in. Random traffic follows: mostly well-formed frames with random
// contents, some bad lengths and bad checksums, and some line noise. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 30;

    localparam sbrp_pkg::t_frame NO_FRAME = '0;
    localparam sbrp_pkg::t_frame WANT_MIN =
        '{1'b0, 8'h00, 8'h00, 3'd0, 32'h0000_0000};
    localparam sbrp_pkg::t_frame WANT_MAX =
        '{1'b0, 8'hFF, 8'hFF, 3'd4, 32'hFFFF_FFFF};
    localparam sbrp_pkg::t_frame WANT_BAD =
        '{1'b1, 8'h55, 8'h55, 3'd0, 32'h0000_0000};

    typedef struct packed {
        logic [7:0]       rx;
        logic             has_want;
        sbrp_pkg::t_frame want;
    } t_stim_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [sbrp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [sbrp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [sbrp_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser;

    // Local copy of the parser state
    logic       hunt_hdr_seen;
    logic       hunt_in_frame;
    logic [3:0] body_pos;
    logic [2:0] body_len;
    logic [7:0] body_sum;
    logic [7:0] body_bytes [6];

    sbrp_pkg::t_frame expected_frames [$];
    t_stim_row        dir_table [DIR_ROWS];

    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          frames_checked = 0;
    int          frames_bad_sum = 0;
    int          frames_dropped = 0;
    int          cycle_count = 0;

    servo_bus_reply_parser_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Guard against a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d frames still expected",
                     cycle_count, expected_frames.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the master side at random
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("MISMATCH @%0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Check each result transaction against the oldest queued frame
    always @(posedge i_clk) begin : check_results
        sbrp_pkg::t_frame want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame, tdata", o_m_axis_tdata, 0);
            end else begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (o_m_axis_tuser[0] !== want.status)
                    report_mismatch("status", o_m_axis_tuser[0], want.status);
                if (o_m_axis_tdata[7:0] !== want.servo_id)
                    report_mismatch("servo_id", o_m_axis_tdata[7:0], want.servo_id);
                if (o_m_axis_tdata[15:8] !== want.command)
                    report_mismatch("command", o_m_axis_tdata[15:8], want.command);
                if (o_m_axis_tdata[18:16] !== want.param_count)
                    report_mismatch("param_count", o_m_axis_tdata[18:16],
                                    want.param_count);
                if (o_m_axis_tdata[26:19] !== want.params[0])
                    report_mismatch("param0", o_m_axis_tdata[26:19], want.params[0]);
                if (o_m_axis_tdata[34:27] !== want.params[1])
                    report_mismatch("param1", o_m_axis_tdata[34:27], want.params[1]);
                if (o_m_axis_tdata[42:35] !== want.params[2])
                    report_mismatch("param2", o_m_axis_tdata[42:35], want.params[2]);
                if (o_m_axis_tdata[50:43] !== want.params[3])
                    report_mismatch("param3", o_m_axis_tdata[50:43], want.params[3]);
            end
        end
    end

    task automatic restart_hunt();
        hunt_hdr_seen = 1'b0;
        hunt_in_frame = 1'b0;
        body_pos      = '0;
        body_len      = '0;
        body_sum      = '0;
    endtask

    // Advance the local parser by one byte; return a frame when one completes
    task automatic parse_reply_byte(input logic [7:0] rx, output bit done,
                                    output sbrp_pkg::t_frame frame);
        logic [2:0] n;
        done  = 1'b0;
        frame = NO_FRAME;
        if (!hunt_in_frame) begin
            if (rx == sbrp_pkg::HDR_BYTE) begin
                if (hunt_hdr_seen) begin
                    restart_hunt();
                    hunt_in_frame = 1'b1;
                end else begin
                    hunt_hdr_seen = 1'b1;
                end
            end else begin
                hunt_hdr_seen = 1'b0;
            end
        end else if (body_pos == 4'd0) begin
            body_bytes[0] = rx;
            body_sum      = body_sum + rx;
            body_pos      = 4'd1;
        end else if (body_pos == 4'd1) begin
            if (rx < sbrp_pkg::LEN_MIN || rx > sbrp_pkg::LEN_MAX) begin
                frames_dropped++;
                restart_hunt();
            end else begin
                body_len = rx[2:0];
                body_sum = body_sum + rx;
                body_pos = 4'd2;
            end
        end else if (body_pos < body_len) begin
            // command or parameter byte
            if (body_pos <= 4'd6)
                body_bytes[body_pos - 1] = rx;
            body_sum = body_sum + rx;
            body_pos = body_pos + 4'd1;
        end else begin
            // checksum byte closes the frame
            n = body_len - sbrp_pkg::PCOUNT_OFS;
            done              = 1'b1;
            frame.status      = (~body_sum != rx);
            frame.servo_id    = body_bytes[0];
            frame.command     = body_bytes[1];
            frame.param_count = n;
            for (int k = 0; k < sbrp_pkg::NUM_PARAMS; k++)
                frame.params[k] = (k < n) ? body_bytes[2 + k] : 8'h00;
            restart_hunt();
        end
    endtask

    // Offer one byte, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] rx, input bit use_typed,
                             input sbrp_pkg::t_frame typed);
        bit               done;
        sbrp_pkg::t_frame frame;
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= rx;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        parse_reply_byte(rx, done, frame);
        if (use_typed)
            frame = typed;
        if (done || use_typed) begin
            if (frame.status)
                frames_bad_sum++;
            expected_frames.push_back(frame);
        end
    endtask

    task automatic send(input logic [7:0] rx);
        send_byte(rx, 1'b0, NO_FRAME);
    endtask

    // Hold the byte side quiet until every queued frame has arrived
    task automatic wait_for_frames();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(negedge i_clk);
    endtask

    // One random chunk: mostly well-formed frames, some bad lengths, some noise
    task automatic send_random_chunk();
        int unsigned kind;
        int unsigned flen;
        logic [7:0]  id;
        logic [7:0]  sum;
        logic [7:0]  b;
        kind = $urandom_range(99);
        id   = ($urandom_range(9) == 0) ? sbrp_pkg::HDR_BYTE : 8'($urandom_range(255));
        if (kind < 78) begin
            flen = $urandom_range(7, 3);
            send(sbrp_pkg::HDR_BYTE);
            send(sbrp_pkg::HDR_BYTE);
            send(id);
            send(8'(flen));
            sum = id + 8'(flen);
            for (int i = 2; i < flen; i++) begin
                b = 8'($urandom_range(255));
                send(b);
                sum = sum + b;
            end
            b = ~sum;
            if ($urandom_range(99) < 12)
                b = 8'($urandom_range(255));
            send(b);
        end else if (kind < 88) begin
            send(sbrp_pkg::HDR_BYTE);
            send(sbrp_pkg::HDR_BYTE);
            send(id);
            if ($urandom_range(1) == 0)
                send(8'($urandom_range(2)));
            else
                send(8'($urandom_range(255, 8)));
        end else begin
            repeat ($urandom_range(4, 1)) begin
                send(($urandom_range(3) == 0) ? sbrp_pkg::HDR_BYTE
                                              : 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_random_phase(input int n_bytes, input int unsigned gap,
                                    input int unsigned stall);
        int target;
        target         = bytes_sent + n_bytes;
        send_gap_pct   = gap;
        recv_stall_pct = stall;
        while (bytes_sent < target)
            send_random_chunk();
    endtask

    initial begin
        restart_hunt();
        for (int i = 0; i < 6; i++)
            body_bytes[i] = 8'h00;

        // Shortest frame, longest frame of all-ones, a short length, and a
        // bad length byte of 0x55 followed by a frame with id 0x55 and a bad
        // checksum
        dir_table = '{
            '{8'h55, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}, '{8'h03, 1'b0, NO_FRAME},
            '{8'h00, 1'b0, NO_FRAME}, '{8'hFC, 1'b1, WANT_MIN},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'h07, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'hFF, 1'b0, NO_FRAME},
            '{8'hFF, 1'b0, NO_FRAME}, '{8'hFE, 1'b1, WANT_MAX},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'h01, 1'b0, NO_FRAME}, '{8'h02, 1'b0, NO_FRAME},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'h01, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h55, 1'b0, NO_FRAME},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h03, 1'b0, NO_FRAME},
            '{8'h55, 1'b0, NO_FRAME}, '{8'h00, 1'b1, WANT_BAD}
        };

        // Hold reset, then release it
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with both sides always ready
        for (int r = 0; r < DIR_ROWS; r++)
            send_byte(dir_table[r].rx, dir_table[r].has_want, dir_table[r].want);
        wait_for_frames();

        // Random traffic under each idling pattern
        run_random_phase(405, 0, 0);
        wait_for_frames();
        run_random_phase(405, 47, 0);
        run_random_phase(405, 0, 47);
        wait_for_frames();
        run_random_phase(405, 6, 6);

        // Drain and let the output stage settle
        wait_for_frames();
        repeat (16) @(negedge i_clk);

        $display("Covered %0d bytes: %0d frames checked, %0d with bad checksum,",
                 bytes_sent, frames_checked, frames_bad_sum);
        $display("%0d frames dropped on length, %0d mismatches",
                 frames_dropped, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
src/sbrp_pkg.sv
src/sbrp_front.sv
src/sbrp_queue.sv
src/sbrp_back.sv
src/servo_bus_reply_parser_top.sv
src/sbrp_checker.sv
sim/tb.sv
